@@ rtl/tepq_pkg.sv @@
// ----------------------------------------------------------------------------
// tepq_pkg
// Shared constants and types for the timed event priority queue.
// ----------------------------------------------------------------------------
package tepq_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int TIME_W    = 32;
  localparam int ADDR_W    = 32;
  localparam int ARG_W     = 32;
  localparam int PENDING_W = 5;

  localparam logic [1:0] KIND_QUEUE = 2'd0;
  localparam logic [1:0] KIND_CHECK = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] due;
    logic              cls;
    logic [ADDR_W-1:0] handler;
    logic [ARG_W-1:0]  arg;
  } entry_t;

  typedef enum logic [2:0] {
    RES_IDLE,
    RES_INS,
    RES_FULL,
    RES_POP,
    RES_CLEAR
  } res_op_t;

  typedef struct packed {
    logic    load;
    logic    rd_top;
    logic    rd_next;
    logic    shift;
    logic    wr_new;
    logic    new_zero;
    logic    res_en;
    res_op_t res_op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       cnt_zero;
    logic       cnt_full;
    logic       enable;
    logic       due_le;
    logic       idx_zero;
  } dp_status_t;

endpackage

@@ rtl/tepq_dp.sv @@
// ----------------------------------------------------------------------------
// tepq_dp
// Datapath: item registers, sorted event memory, count, flags and results.
// ----------------------------------------------------------------------------
module tepq_dp
  import tepq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [1:0]           kind,
  input  logic [TIME_W-1:0]    event_time,
  input  logic                 handler_class,
  input  logic [ADDR_W-1:0]    handler_addr,
  input  logic [ARG_W-1:0]     argument,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  output logic                 delivered,
  output logic                 out_class,
  output logic [ADDR_W-1:0]    out_handler,
  output logic [ARG_W-1:0]     out_argument,
  output logic                 queue_full,
  output logic [PENDING_W-1:0] pending,
  output logic                 delivered_seen
);

  entry_t           mem [DEPTH];
  entry_t           rdata;
  entry_t           item;
  logic [1:0]       item_kind;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic             flag;
  logic             enable;

  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] idx_up;
  logic [IDX_W-1:0] idx_dn;
  logic [IDX_W-1:0] new_addr;

  assign cnt_m1   = count - CNT_W'(1);
  assign top_idx  = cnt_m1[IDX_W-1:0];
  assign idx_up   = idx + IDX_W'(1);
  assign idx_dn   = idx - IDX_W'(1);
  assign new_addr = cmd.new_zero ? IDX_W'(0) : idx_up;

  assign status.kind     = item_kind;
  assign status.cnt_zero = (count == CNT_W'(0));
  assign status.cnt_full = (count >= CNT_W'(DEPTH));
  assign status.enable   = enable;
  assign status.due_le   = (rdata.due <= item.due);
  assign status.idx_zero = (idx == IDX_W'(0));

  assign pending        = PENDING_W'(count);
  assign delivered_seen = flag;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind    <= kind;
      item.due     <= event_time;
      item.cls     <= handler_class;
      item.handler <= handler_addr;
      item.arg     <= argument;
    end
    if (cmd.rd_top) begin
      rdata <= mem[top_idx];
      idx   <= top_idx;
    end else if (cmd.rd_next) begin
      rdata <= mem[idx_dn];
      idx   <= idx_dn;
    end
    if (cmd.shift) begin
      mem[idx_up] <= rdata;
    end else if (cmd.wr_new) begin
      mem[new_addr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      flag   <= 1'b0;
      enable <= 1'b1;
    end else begin
      if (cfg_we) begin
        enable <= cfg_data;
      end
      if (cmd.res_en) begin
        unique case (cmd.res_op)
          RES_INS:   count <= count + CNT_W'(1);
          RES_POP: begin
            count <= cnt_m1;
            flag  <= 1'b1;
          end
          RES_CLEAR: flag <= 1'b0;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      delivered    <= (cmd.res_op == RES_POP);
      queue_full   <= (cmd.res_op == RES_FULL);
      if (cmd.res_op == RES_POP) begin
        out_class    <= rdata.cls;
        out_handler  <= rdata.handler;
        out_argument <= rdata.arg;
      end else begin
        out_class    <= 1'b0;
        out_handler  <= '0;
        out_argument <= '0;
      end
    end
  end

endmodule

@@ rtl/tepq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tepq_ctrl
// Controller: sequences insert walks, pops and flag updates for one item.
// ----------------------------------------------------------------------------
module tepq_ctrl
  import tepq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_NEW0,
    S_POP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.res_op = RES_IDLE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.kind)
          KIND_QUEUE: begin
            if (status.cnt_full) begin
              cmd.res_en = 1'b1;
              cmd.res_op = RES_FULL;
              state_next = S_IDLE;
            end else if (status.cnt_zero) begin
              cmd.wr_new   = 1'b1;
              cmd.new_zero = 1'b1;
              cmd.res_en   = 1'b1;
              cmd.res_op   = RES_INS;
              state_next   = S_IDLE;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = S_WALK;
            end
          end
          KIND_CHECK: begin
            if (status.cnt_zero || !status.enable) begin
              cmd.res_en = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.rd_top = 1'b1;
              state_next = S_POP;
            end
          end
          KIND_CLEAR: begin
            cmd.res_en = 1'b1;
            cmd.res_op = RES_CLEAR;
            state_next = S_IDLE;
          end
          default: begin
            cmd.res_en = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        if (status.due_le) begin
          cmd.shift = 1'b1;
          if (status.idx_zero) begin
            state_next = S_NEW0;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end else begin
          cmd.wr_new = 1'b1;
          cmd.res_en = 1'b1;
          cmd.res_op = RES_INS;
          state_next = S_IDLE;
        end
      end
      S_NEW0: begin
        cmd.wr_new   = 1'b1;
        cmd.new_zero = 1'b1;
        cmd.res_en   = 1'b1;
        cmd.res_op   = RES_INS;
        state_next   = S_IDLE;
      end
      S_POP: begin
        cmd.res_en = 1'b1;
        cmd.res_op = status.due_le ? RES_POP : RES_IDLE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.res_en;
      if (cmd.load) begin
        busy <= 1'b1;
      end else if (cmd.res_en) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/timed_event_priority_queue.sv @@
// ----------------------------------------------------------------------------
// timed_event_priority_queue
// Keeps up to DEPTH timed events sorted by due time and delivers due ones.
//
//   Channel   Handshake               Beat contents
//   command   start, busy             kind, event_time, handler_class,
//                                     handler_addr, argument
//   result    done (one-cycle)        delivered, out_class, out_handler,
//                                     out_argument, queue_full, pending,
//                                     delivered_seen
//   config    cfg_valid, cfg_ready    cfg_data (delivery_enable)
//
// A command beat is taken when start is high and busy is low; its result
// is strobed by done once the controller returns to idle. A check that
// reads the queue head passes through an extra pop state, and an insert
// into a non-empty queue walks the event memory one entry per cycle from
// the head down past every entry due at or before the new one. Synchronous
// reset empties the queue, clears the sticky flag and enables delivery.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module timed_event_priority_queue
  import tepq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           kind,
  input  logic [TIME_W-1:0]    event_time,
  input  logic                 handler_class,
  input  logic [ADDR_W-1:0]    handler_addr,
  input  logic [ARG_W-1:0]     argument,
  output logic                 done,
  output logic                 delivered,
  output logic                 out_class,
  output logic [ADDR_W-1:0]    out_handler,
  output logic [ARG_W-1:0]     out_argument,
  output logic                 queue_full,
  output logic [PENDING_W-1:0] pending,
  output logic                 delivered_seen,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tepq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  tepq_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .kind           (kind),
    .event_time     (event_time),
    .handler_class  (handler_class),
    .handler_addr   (handler_addr),
    .argument       (argument),
    .cfg_we         (cfg_valid & cfg_ready),
    .cfg_data       (cfg_data),
    .delivered      (delivered),
    .out_class      (out_class),
    .out_handler    (out_handler),
    .out_argument   (out_argument),
    .queue_full     (queue_full),
    .pending        (pending),
    .delivered_seen (delivered_seen)
  );

endmodule

@@ dv/timed_event_priority_queue_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_event_priority_queue_test
// Self-checking testbench for the timed event priority queue.
//
// Commands go in through the start/busy port and a predictor of the sorted
// event store works out each result beat. A checker compares every done
// beat with the oldest prediction, field by field. Directed tests cover the
// field extremes, the full store, equal due times, empty and held checks
// and the unused kind. Random traffic then runs in phases with different
// command mixes and delivery settings, with bursts of sender idling in all but the last phase.
// ----------------------------------------------------------------------------
module timed_event_priority_queue_test;
  import tepq_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         NUM_PHASES  = 6;
  localparam int         PHASE_ITEMS = 145;

  typedef struct packed {
    logic                 delivered;
    logic                 cls;
    logic [ADDR_W-1:0]    handler;
    logic [ARG_W-1:0]     arg;
    logic                 full;
    logic [PENDING_W-1:0] pending;
    logic                 seen;
  } queue_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           kind = KIND_QUEUE;
  logic [TIME_W-1:0]    event_time = '0;
  logic                 handler_class = 1'b0;
  logic [ADDR_W-1:0]    handler_addr = '0;
  logic [ARG_W-1:0]     argument = '0;
  logic                 done;
  logic                 delivered;
  logic                 out_class;
  logic [ADDR_W-1:0]    out_handler;
  logic [ARG_W-1:0]     out_argument;
  logic                 queue_full;
  logic [PENDING_W-1:0] pending;
  logic                 delivered_seen;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;

  entry_t        model_events [DEPTH];
  int            model_count = 0;
  logic          model_seen = 1'b0;
  logic          model_enable = 1'b1;
  queue_result_t expected_outcomes [$];
  logic [31:0]   sim_now = 32'h80;
  int            mismatch_count = 0;
  int            items_sent = 0;
  int            deliveries = 0;
  int            dropped_inserts = 0;
  int            enable_writes = 0;

  timed_event_priority_queue u_dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic queue_result_t model_timer_item(input logic [1:0] k,
      input logic [31:0] t, input logic c, input logic [31:0] h, input logic [31:0] a);
    queue_result_t r;
    int slot;
    r = '0;
    case (k)
      KIND_QUEUE: begin
        if (model_count >= DEPTH) begin
          r.full = 1'b1;
          dropped_inserts++;
        end else begin
          slot = model_count;
          for (int i = 0; i < model_count; i++) begin
            if (t >= model_events[i].due) begin
              slot = i;
              break;
            end
          end
          for (int i = model_count; i > slot; i--) model_events[i] = model_events[i-1];
          model_events[slot] = '{due: t, cls: c, handler: h, arg: a};
          model_count++;
        end
      end
      KIND_CHECK: begin
        if (model_count > 0 && model_enable && t >= model_events[model_count-1].due) begin
          model_count--;
          r.delivered = 1'b1;
          r.cls = model_events[model_count].cls;
          r.handler = model_events[model_count].handler;
          r.arg = model_events[model_count].arg;
          model_seen = 1'b1;
          deliveries++;
        end
      end
      KIND_CLEAR: model_seen = 1'b0;
      default: ;
    endcase
    r.pending = PENDING_W'(model_count);
    r.seen = model_seen;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
      input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result beat with no command outstanding");
      end else begin
        want = expected_outcomes.pop_front();
        compare_field("delivered", 32'(delivered), 32'(want.delivered));
        compare_field("out_class", 32'(out_class), 32'(want.cls));
        compare_field("out_handler", out_handler, want.handler);
        compare_field("out_argument", out_argument, want.arg);
        compare_field("queue_full", 32'(queue_full), 32'(want.full));
        compare_field("pending", 32'(pending), 32'(want.pending));
        compare_field("delivered_seen", 32'(delivered_seen), 32'(want.seen));
      end
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [31:0] t, input logic c,
      input logic [31:0] h, input logic [31:0] a, input bit allow_gap);
    start <= 1'b1;
    kind <= k;
    event_time <= t;
    handler_class <= c;
    handler_addr <= h;
    argument <= a;
    do @(posedge clk); while (busy);
    expected_outcomes.push_back(model_timer_item(k, t, c, h, a));
    items_sent++;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0);
  endtask

  task automatic write_delivery_enable(input logic value);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_enable = value;
    enable_writes++;
  endtask

  task automatic test_basic_events();
    write_delivery_enable(1'b1);
    send_item(KIND_CHECK, 32'h0, 1'b0, 32'h0, 32'h0, 1'b0);
    send_item(KIND_QUEUE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_QUEUE, 32'h0, 1'b0, 32'h0, 32'h0, 1'b0);
    send_item(KIND_CHECK, 32'h0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_CLEAR, 32'h0, 1'b0, 32'h0, 32'h0, 1'b0);
    send_item(KIND_CHECK, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0);
  endtask

  // Equal due times fill the store, so later pops also check first-in,
  // first-out order among them.
  task automatic test_full_store();
    for (int i = 0; i <= DEPTH; i++)
      send_item(KIND_QUEUE, 32'h100, i[0], 32'(i), $urandom(), 1'b1);
  endtask

  task automatic test_delivery_hold();
    write_delivery_enable(1'b0);
    send_item(KIND_CHECK, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0);
    write_delivery_enable(1'b1);
  endtask

  task automatic send_random_item(input int queue_pct, input int check_pct,
      input bit allow_gap);
    int roll;
    logic [1:0] k;
    logic [31:0] t;
    roll = $urandom_range(0, 99);
    if (roll < queue_pct) begin
      k = KIND_QUEUE;
      roll = $urandom_range(0, 99);
      if (roll < 10) t = $urandom();
      else if (roll < 12) t = 32'h0;
      else if (roll < 14) t = 32'hFFFF_FFFF;
      else t = sim_now + $urandom_range(0, 200);
    end else if (roll < queue_pct + check_pct) begin
      k = KIND_CHECK;
      sim_now += $urandom_range(0, 20);
      t = ($urandom_range(0, 9) == 0) ? $urandom() : sim_now + $urandom_range(0, 50);
    end else begin
      k = ($urandom_range(0, 4) == 0) ? KIND_UNUSED : KIND_CLEAR;
      t = $urandom();
    end
    send_item(k, t, 1'($urandom_range(0, 1)), $urandom(), $urandom(), allow_gap);
  endtask

  task automatic test_random_traffic();
    int queue_mix [NUM_PHASES] = '{40, 60, 40, 30, 50, 45};
    int check_mix [NUM_PHASES] = '{45, 30, 45, 60, 40, 45};
    logic enable_by_phase [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_delivery_enable(enable_by_phase[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_random_item(queue_mix[p], check_mix[p], p != NUM_PHASES - 1);
        if (p != NUM_PHASES - 1 && $urandom_range(0, 49) == 0) wait_for_results();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_events();
    test_full_store();
    test_delivery_hold();
    test_random_traffic();
    wait_for_results();
    repeat (DEPTH + 4) @(posedge clk);
    $display("Ran %0d commands across %0d delivery settings.", items_sent, enable_writes);
    $display("Saw %0d deliveries and %0d inserts dropped on a full store.",
             deliveries, dropped_inserts);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
